/* rtl/ssbc_pkg.sv */
// ----------------------------------------------------------------------------
// ssbc_pkg
// Shared constants and types of the spread sketch bitmap counter.
// ----------------------------------------------------------------------------
package ssbc_pkg;

  localparam int unsigned MaxColumns    = 1024;
  localparam int unsigned MaxBitmapBits = 2048;
  localparam int unsigned WordBits      = 64;
  localparam int unsigned WordsPerCol   = MaxBitmapBits / WordBits;
  localparam int unsigned ColW          = $clog2(MaxColumns);
  localparam int unsigned WordIdxW      = $clog2(WordsPerCol);
  localparam int unsigned BitIdxW       = $clog2(WordBits);
  localparam int unsigned AddrW         = ColW + WordIdxW;
  localparam int unsigned BitsW         = 12;  // bitmap_bits register and ones_count
  localparam int unsigned ColsW         = 11;  // table column registers
  localparam int unsigned EstW          = 14;
  localparam int unsigned LogW          = 20;  // Q16 log2 with 4 integer bits
  localparam int unsigned KeyW          = 32;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [31:0]     Ln2Q32 = 32'd2977044472;
  localparam logic [EstW-1:0] EstMax = '1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTable0 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTable1 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTable2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBits   = 2'd3;

  // commands
  localparam logic CmdUpdate = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef struct packed {
    logic                we;
    logic [AddrW-1:0]    addr;
    logic [WordBits-1:0] wdata;
  } mem_req_t;

endpackage

/* rtl/ssbc_divider.sv */
// ----------------------------------------------------------------------------
// ssbc_divider
// Restoring remainder unit: 32-bit dividend modulo a 12-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssbc_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ssbc_pkg::KeyW-1:0]  dividend_i,
  input  logic [ssbc_pkg::BitsW-1:0] divisor_i,
  output logic                       done_o,
  output logic [ssbc_pkg::BitsW-1:0] rem_o
);
  import ssbc_pkg::*;

  localparam int unsigned CntW = $clog2(KeyW + 1);

  logic [KeyW-1:0]  dvd_q;
  logic [BitsW-1:0] dvs_q;
  logic [BitsW-1:0] rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [BitsW:0]   trial;
  logic [BitsW:0]   diff;

  assign trial = {rem_q, dvd_q[KeyW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(KeyW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[KeyW-2:0], 1'b0};
      // remainder stays below the divisor, so the top bit drops out
      rem_q <= diff[BitsW] ? trial[BitsW-1:0] : diff[BitsW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/ssbc_log2.sv */
// ----------------------------------------------------------------------------
// ssbc_log2
// log2 of a 12-bit integer in Q16: leading-one position for the integer
// part, then 16 rounds of squaring a Q30 mantissa, one round per cycle.
// ----------------------------------------------------------------------------
module ssbc_log2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ssbc_pkg::BitsW-1:0] n_i,
  output logic                       done_o,
  output logic [ssbc_pkg::LogW-1:0]  log_o
);
  import ssbc_pkg::*;

  localparam int unsigned FracW = 16;
  localparam int unsigned XW    = 31;

  logic [3:0]       k;
  logic [3:0]       k_q;
  logic [FracW-1:0] frac_q;
  logic [XW-1:0]    x_q;
  logic [4:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [2*XW-1:0]  sq;
  logic [31:0]      y;

  always_comb begin
    k = '0;
    for (int i = 1; i < BitsW; i++) begin
      if (n_i[i]) k = 4'(i);
    end
  end

  assign sq = x_q * x_q;
  assign y  = sq[61:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(FracW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      k_q    <= k;
      frac_q <= '0;
      x_q    <= XW'({19'd0, n_i} << (5'd30 - {1'b0, k}));
    end else if (busy_q) begin
      if (y[31]) begin
        x_q    <= y[31:1];
        frac_q <= {frac_q[FracW-2:0], 1'b1};
      end else begin
        x_q    <= y[XW-1:0];
        frac_q <= {frac_q[FracW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign log_o  = {k_q, frac_q};

endmodule

/* rtl/ssbc_store.sv */
// ----------------------------------------------------------------------------
// ssbc_store
// Column word store: single port, 64-bit words, registered read data.
// ----------------------------------------------------------------------------
module ssbc_store (
  input  logic                          clk_i,
  input  ssbc_pkg::mem_req_t            req_i,
  output logic [ssbc_pkg::WordBits-1:0] rdata_o
);
  import ssbc_pkg::*;

  localparam int unsigned Depth = MaxColumns * WordsPerCol;

  logic [WordBits-1:0] mem_q [Depth];
  logic [WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/spread_sketch_bitmap_counter_top.sv */
// ----------------------------------------------------------------------------
// spread_sketch_bitmap_counter_top
// Three-table linear counting sketch over one column word store.
//
//  channel  dir  beat contents
//  s_axis   in   tuser: command; tdata: flow_key[31:0], element_hash[63:32]
//  m_axis   out  tdata: ones_count[11:0], spread_estimate[25:12], zero pad
//  cfg      in   cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// Update: three key remainders and the hash remainder on one serial divider,
// then three read-modify-writes, each a read state and a write state; the
// next beat is taken once the engine is back in idle.
// Query: three remainders, then per 64-bit word in use (up to 32 words) the
// three tables' words are read and ANDed and the ones counted, then two log2
// passes, the ln scaling and the estimate. After reset all 32768 store words
// are zeroed, one word a cycle, with s_axis_tready low. A result waiting on
// m_axis holds the next one back only when that one is ready; inputs are taken whenever the engine is idle.
// ----------------------------------------------------------------------------
module spread_sketch_bitmap_counter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // flow_key, element_hash
  input  logic [0:0]                   s_axis_tuser,  // command
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // ones_count, spread_estimate
  input  logic                         cfg_we_i,
  input  logic [ssbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ssbc_pkg::BitsW-1:0]   cfg_data_i
);
  import ssbc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_UPD_RD, S_UPD_WR, S_Q_RD, S_Q_ACC, S_Q_POP,
    S_LOG_V, S_LOG_Z, S_LN, S_EST, S_OUT
  } state_e;

  state_e state_q;

  logic [ColsW-1:0] cols_q [3];
  logic [BitsW-1:0] bits_q;

  logic             cmd_q;
  logic [KeyW-1:0]  key_q, hash_q;
  logic [BitsW-1:0] v_q;
  logic [ColsW-1:0] meff [3];
  logic [BitsW-1:0] base [3];
  logic [ColW-1:0]  col_q [3];
  logic [1:0]       sel_q;
  logic [1:0]       t_q;
  logic [10:0]      bitpos_q;
  logic [WordIdxW-1:0] w_q;
  logic [WordBits-1:0] and_q;
  logic [BitsW-1:0]    ones_q;
  logic [LogW-1:0]     l2v_q, l2z_q;
  logic [LogW-1:0]     lnq_q;
  logic [EstW-1:0]     est_q;
  logic [AddrW-1:0]    clr_q;

  logic             div_start_q, div_done;
  logic [KeyW-1:0]  div_dvd;
  logic [BitsW-1:0] div_dvs, div_rem;
  logic             log_start_q, log_done;
  logic [BitsW-1:0] log_n, zeros;
  logic [LogW-1:0]  log_res;

  mem_req_t            mreq;
  logic [WordBits-1:0] rdata;

  logic [BitsW-1:0]    word_rem;
  logic [WordBits-1:0] word_mask;
  logic [BitsW-1:0]    pop;
  logic [BitsW-1:0]    lo_next;
  logic [LogW-1:0]     dlog;
  logic [51:0]         ln_prod;
  logic [31:0]         est_prod;
  logic [BitsW:0]      col_sum;

  logic                m_valid_q;
  logic [31:0]         m_data_q;

  // effective column counts and table bases
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      meff[i] = (cols_q[i] == '0) ? ColsW'(1) : cols_q[i];
    end
    base[0] = '0;
    base[1] = BitsW'(meff[0]);
    base[2] = BitsW'(meff[0]) + BitsW'(meff[1]);
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q[0] <= ColsW'(331);
      cols_q[1] <= ColsW'(337);
      cols_q[2] <= ColsW'(347);
      bits_q    <= BitsW'(2048);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTable0: cols_q[0] <= cfg_data_i[ColsW-1:0];
        RegTable1: cols_q[1] <= cfg_data_i[ColsW-1:0];
        RegTable2: cols_q[2] <= cfg_data_i[ColsW-1:0];
        RegBits:   bits_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign div_dvd = (sel_q == 2'd3) ? hash_q : key_q;
  assign div_dvs = (sel_q == 2'd3) ? v_q : BitsW'(meff[sel_q]);

  ssbc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign zeros = (v_q == ones_q) ? BitsW'(1) : v_q - ones_q;
  assign log_n = (state_q == S_LOG_Z) ? zeros : v_q;

  ssbc_log2 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start_q),
    .n_i     (log_n),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  always_comb begin
    mreq.we    = 1'b0;
    mreq.addr  = {col_q[t_q], w_q};
    mreq.wdata = rdata | (WordBits'(1) << bitpos_q[BitIdxW-1:0]);
    unique case (state_q)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.addr  = clr_q;
        mreq.wdata = '0;
      end
      S_UPD_RD: mreq.addr = {col_q[t_q], bitpos_q[10:6]};
      S_UPD_WR: begin
        mreq.we   = 1'b1;
        mreq.addr = {col_q[t_q], bitpos_q[10:6]};
      end
      default: ;
    endcase
  end

  ssbc_store u_store (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // tail mask of the current word and its population count
  assign word_rem  = v_q - {w_q, 6'd0};
  assign word_mask = (word_rem < BitsW'(WordBits)) ? ~({WordBits{1'b1}} << word_rem[5:0])
                                                   : {WordBits{1'b1}};
  always_comb begin
    pop = '0;
    for (int i = 0; i < WordBits; i++) begin
      pop = pop + BitsW'(and_q[i] & word_mask[i]);
    end
  end
  assign lo_next = BitsW'({1'b0, w_q} + 6'd1) << 6;

  assign dlog     = (l2v_q > l2z_q) ? l2v_q - l2z_q : '0;
  assign ln_prod  = dlog * Ln2Q32;
  assign est_prod = v_q * lnq_q;
  assign col_sum  = {1'b0, base[sel_q]} + {1'b0, div_rem};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      div_start_q <= 1'b0;
      log_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
      sel_q       <= '0;
      t_q         <= '0;
      w_q         <= '0;
    end else begin
      div_start_q <= 1'b0;
      log_start_q <= 1'b0;
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sel_q       <= '0;
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (sel_q == 2'd3) begin
              t_q     <= '0;
              state_q <= S_UPD_RD;
            end else if (sel_q == 2'd2 && cmd_q == CmdQuery) begin
              t_q     <= '0;
              w_q     <= '0;
              state_q <= S_Q_RD;
            end else begin
              sel_q       <= sel_q + 1'b1;
              div_start_q <= 1'b1;
            end
          end
        end
        S_UPD_RD: state_q <= S_UPD_WR;
        S_UPD_WR: begin
          if (t_q == 2'd2) begin
            state_q <= S_IDLE;
          end else begin
            t_q     <= t_q + 1'b1;
            state_q <= S_UPD_RD;
          end
        end
        S_Q_RD: state_q <= S_Q_ACC;
        S_Q_ACC: begin
          if (t_q == 2'd2) begin
            state_q <= S_Q_POP;
          end else begin
            t_q     <= t_q + 1'b1;
            state_q <= S_Q_RD;
          end
        end
        S_Q_POP: begin
          t_q <= '0;
          if (&w_q || lo_next >= v_q) begin
            log_start_q <= 1'b1;
            state_q     <= S_LOG_V;
          end else begin
            w_q     <= w_q + 1'b1;
            state_q <= S_Q_RD;
          end
        end
        S_LOG_V: begin
          if (log_done) begin
            log_start_q <= 1'b1;
            state_q     <= S_LOG_Z;
          end
        end
        S_LOG_Z: if (log_done) state_q <= S_LN;
        S_LN:    state_q <= S_EST;
        S_EST:   state_q <= S_OUT;
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q  <= s_axis_tuser[0];
        key_q  <= s_axis_tdata[31:0];
        hash_q <= s_axis_tdata[63:32];
        if (bits_q == '0) begin
          v_q <= BitsW'(1);
        end else if (bits_q > BitsW'(MaxBitmapBits)) begin
          v_q <= BitsW'(MaxBitmapBits);
        end else begin
          v_q <= bits_q;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (sel_q == 2'd3) begin
            bitpos_q <= div_rem[10:0];
          end else begin
            col_q[sel_q] <= col_sum[ColW-1:0];
          end
          ones_q <= '0;
          and_q  <= '1;
        end
      end
      S_Q_ACC: and_q <= and_q & rdata;
      S_Q_POP: begin
        ones_q <= ones_q + pop;
        and_q  <= '1;
      end
      S_LOG_V: if (log_done) l2v_q <= log_res;
      S_LOG_Z: if (log_done) l2z_q <= log_res;
      S_LN:    lnq_q <= ln_prod[51:32];
      S_EST:   est_q <= (est_prod[31:16] > 16'(EstMax)) ? EstMax : est_prod[EstW+15:16];
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {6'd0, est_q, ones_q};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* test/spread_sketch_bitmap_counter_top_tb.sv */
// ----------------------------------------------------------------------------
// spread_sketch_bitmap_counter_top_tb
// Self-checking bench for the three-table spread sketch. Update and query
// beats go in on s_axis; each query result on m_axis is checked field by field
// against a bit-exact predictor with its own copy of the column store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spread_sketch_bitmap_counter_top_tb;
  import ssbc_pkg::*;

  typedef struct {
    logic          cmd;
    logic [31:0]   key;
    logic [31:0]   hash;
  } sketch_op_t;

  typedef struct {
    logic [BitsW-1:0] ones;
    logic [EstW-1:0]  est;
  } spread_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata = '0;   // flow_key, element_hash
  logic [0:0]          s_axis_tuser = '0;   // command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;        // ones_count, spread_estimate
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [BitsW-1:0]    cfg_data_i = '0;

  spread_sketch_bitmap_counter_top uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [MaxBitmapBits-1:0] sketch_cols [MaxColumns];
  logic [ColsW-1:0]         table_cols [3];
  logic [BitsW-1:0]         bitmap_size;

  sketch_op_t pending_ops[$];
  spread_t    expected_spreads[$];
  int         mismatches = 0;
  int         ops_sent = 0;
  int         queries_sent = 0;
  int         spreads_seen = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  bit         long_hold_done = 1'b0;
  logic [31:0] key_pool [8];

  function automatic int unsigned eff_cols(int t);
    return (table_cols[t] == 0) ? 1 : table_cols[t];
  endfunction

  function automatic int unsigned eff_bits();
    int unsigned v;
    v = (bitmap_size == 0) ? 1 : bitmap_size;
    return (v > MaxBitmapBits) ? MaxBitmapBits : v;
  endfunction

  function automatic int unsigned column_for(int t, logic [31:0] key);
    int unsigned base;
    base = 0;
    for (int i = 0; i < t; i++) base += eff_cols(i);
    return (base + key % eff_cols(t)) % MaxColumns;
  endfunction

  // Q16 log2 by repeated squaring of a Q30 mantissa
  function automatic logic [31:0] log2_q16(int unsigned n);
    int unsigned k;
    logic [31:0] frac;
    logic [63:0] x;
    k = 0;
    frac = 0;
    if (n == 0) n = 1;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    x = 64'(n) << (30 - k);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return (k << 16) | frac;
  endfunction

  task automatic apply_op(sketch_op_t op);
    int unsigned v, b, ones, zeros, c0, c1, c2;
    logic [31:0] l2v, l2z, d;
    logic [63:0] lnq, est;
    logic [MaxBitmapBits-1:0] anded, mask;
    spread_t r;
    v = eff_bits();
    c0 = column_for(0, op.key);
    c1 = column_for(1, op.key);
    c2 = column_for(2, op.key);
    if (op.cmd == CmdUpdate) begin
      b = op.hash % v;
      sketch_cols[c0][b] = 1'b1;
      sketch_cols[c1][b] = 1'b1;
      sketch_cols[c2][b] = 1'b1;
    end else begin
      mask = (v == MaxBitmapBits) ? '1 : ((MaxBitmapBits'(1) << v) - 1);
      anded = sketch_cols[c0] & sketch_cols[c1] & sketch_cols[c2] & mask;
      ones = $countones(anded);
      zeros = (v - ones == 0) ? 1 : v - ones;
      l2v = log2_q16(v);
      l2z = log2_q16(zeros);
      d = (l2v > l2z) ? l2v - l2z : 0;
      lnq = (64'(d) * 64'(Ln2Q32)) >> 32;
      est = (64'(v) * lnq) >> 16;
      r.ones = ones[BitsW-1:0];
      r.est = (est > 64'(EstMax)) ? EstMax : est[EstW-1:0];
      expected_spreads.insert(expected_spreads.size(), r);
      queries_sent++;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sketch_op_t op;
        op.cmd = s_axis_tuser[0];
        op.key = s_axis_tdata[31:0];
        op.hash = s_axis_tdata[63:32];
        apply_op(op);
        ops_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          sketch_op_t nxt;
          nxt = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt.cmd;
          s_axis_tdata <= {nxt.hash, nxt.key};
          send_gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor; one long hold-off early on lets the block back up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_spreads.size() == 0) begin
          report_mismatch("unexpected beat, ones_count", m_axis_tdata[11:0], -1);
        end else begin
          spread_t want;
          want = expected_spreads.pop_front();
          if (m_axis_tdata[11:0] !== want.ones)
            report_mismatch("ones_count", m_axis_tdata[11:0], want.ones);
          if (m_axis_tdata[25:12] !== want.est)
            report_mismatch("spread_estimate", m_axis_tdata[25:12], want.est);
        end
        spreads_seen++;
      end
      if (!long_hold_done && spreads_seen == 5) begin
        long_hold_done <= 1'b1;
        hold_left <= 3000;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || s_axis_tvalid || expected_spreads.size() > 0)
      @(posedge clk_i);
    wait_cycles(400);  // an update may still be in flight
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[BitsW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegBits) bitmap_size = val[BitsW-1:0];
    else table_cols[idx] = val[ColsW-1:0];
  endtask

  task automatic push_op(logic cmd, logic [31:0] key, logic [31:0] hash);
    sketch_op_t op;
    op.cmd = cmd;
    op.key = key;
    op.hash = hash;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // mostly updates on a few hot flows so that bitmaps fill, queries mixed in
  task automatic random_ops(int n);
    logic [31:0] key;
    for (int i = 0; i < n; i++) begin
      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : $urandom;
      push_op(($urandom_range(99) < 30) ? CmdQuery : CmdUpdate, key, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < MaxColumns; i++) sketch_cols[i] = '0;
    table_cols[0] = 331;
    table_cols[1] = 337;
    table_cols[2] = 347;
    bitmap_size = 2048;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom;

    wait_cycles(6);
    rst_ni <= 1'b1;

    // directed: empty query, field extremes, hash bit extremes, repeated hits
    push_op(CmdQuery, 32'h0, 32'h0);
    push_op(CmdUpdate, 32'h0, 32'h0);
    push_op(CmdUpdate, 32'h0, 32'hFFFF_FFFF);
    push_op(CmdUpdate, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(CmdUpdate, 32'hFFFF_FFFF, 32'h0000_07FF);
    push_op(CmdUpdate, 32'h0, 32'h0);
    push_op(CmdQuery, 32'h0, 32'hFFFF_FFFF);
    push_op(CmdQuery, 32'hFFFF_FFFF, 32'h0);
    push_op(CmdQuery, 32'h1234_5678, 32'h0);
    for (int i = 0; i < 10; i++) push_op(CmdQuery, key_pool[i % 8], $urandom);
    random_ops(90);
    wait_drained();

    // single column per table: every key shares one bitmap, fills quickly
    write_reg(RegTable0, 1);
    write_reg(RegTable1, 1);
    write_reg(RegTable2, 1);
    write_reg(RegBits, 8);
    random_ops(60);
    wait_drained();  // sender holds off until every result is back
    random_ops(50);
    wait_drained();

    // zero registers act as one
    write_reg(RegTable0, 0);
    write_reg(RegTable1, 0);
    write_reg(RegTable2, 0);
    write_reg(RegBits, 0);
    random_ops(60);
    wait_drained();

    // oversized tables wrap the store, oversized bitmap clamps
    write_reg(RegTable0, 1024);
    write_reg(RegTable1, 1024);
    write_reg(RegTable2, 1024);
    write_reg(RegBits, 4095);
    random_ops(110);
    wait_drained();

    // shrink the bitmap: stale upper bits must not count
    write_reg(RegTable0, 1024);
    write_reg(RegTable1, 5);
    write_reg(RegTable2, 3);
    write_reg(RegBits, 64);
    random_ops(110);
    wait_drained();

    write_reg(RegTable0, 7);
    write_reg(RegTable1, 11);
    write_reg(RegTable2, 13);
    write_reg(RegBits, 65);
    random_ops(100);
    wait_drained();

    write_reg(RegTable0, 331);
    write_reg(RegTable1, 337);
    write_reg(RegTable2, 347);
    write_reg(RegBits, 2048);
    random_ops(100);
    wait_drained();

    $display("Run covered %0d beats (%0d queries, %0d results) over 7 table/bitmap settings.",
             ops_sent, queries_sent, spreads_seen);
    $display("Settings included zero, one and 1024 columns and bitmaps of 0 to 4095 bits.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still expected", expected_spreads.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
